// File: src/dmwbc_pkg.sv
// Shared types and codes of the direct-mapped write-back cache controller.
`timescale 1ns / 1ps

package dmwbc_pkg;

    // Request and completion report codes
    typedef enum logic [1:0] {
        REQ_READ    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_WB_DONE = 2'd2,
        REQ_FILL_DONE = 2'd3
    } t_req_type;

    // Response codes
    typedef enum logic [2:0] {
        RESP_DONE  = 3'd0,
        RESP_WBACK = 3'd1,
        RESP_FILL  = 3'd2,
        RESP_IOERR = 3'd3,
        RESP_ORDER = 3'd4
    } t_resp_kind;

    // Wait phase of the controller, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_WBACK = 3'b010,
        PH_FILL  = 3'b100
    } t_phase;

endpackage

// File: src/dmwbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dmwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/direct_mapped_writeback_cache.sv
// Tag and control path of a direct-mapped write-back block cache.
`timescale 1ns / 1ps

// Usage:
//   Command side: drive i_req_type, i_block_number and i_io_ok and raise start;
//   the item is taken at a rising edge where start is high and busy is low.
//   Read and write requests name a block; writeback-done and fill-done reports
//   carry the backing store status in i_io_ok.
//   Result side: o_resp_strobe is high for exactly one cycle with o_resp_kind,
//   o_slot, o_target_block and o_was_hit. The receiver cannot hold it off.
//   The accepted item is held in r_exec, then r_strobe drives the result strobe.
//   The block takes no new item while one is under work. The entry store (valid,
//   dirty, tag per slot) is a RAM with one read port and registered read data;
//   an item first reads its entry, then compares it and writes the entry back,
//   and busy stays high during the compare and write-back.
//   Reset (synchronous, i_rst_n low): the wait phase returns to idle, and then
//   a clearing pass writes every entry invalid, one slot per cycle, through the
//   last slot; busy is high during the pass. SLOTS must be a power of two.
module direct_mapped_writeback_cache #(
    parameter int SLOTS      = 64,
    parameter int BLOCK_BITS = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_req_type,
    input  logic [BLOCK_BITS-1:0]    i_block_number,
    input  logic                     i_io_ok,
    output logic                     o_resp_strobe,
    output logic [2:0]               o_resp_kind,
    output logic [$clog2(SLOTS)-1:0] o_slot,
    output logic [BLOCK_BITS-1:0]    o_target_block,
    output logic                     o_was_hit
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TAG_W  = BLOCK_BITS - SLOT_W;
    localparam int ENT_W  = TAG_W + 2;

    // Control state
    logic                   r_clear;
    logic [SLOT_W-1:0]      r_clr_idx;
    logic                   r_exec;
    dmwbc_pkg::t_phase      r_phase, n_phase;
    logic [BLOCK_BITS-1:0]  r_pend_blk, n_pend_blk;
    logic                   r_pend_wr, n_pend_wr;

    // Captured item
    dmwbc_pkg::t_req_type   r_req_type;
    logic [BLOCK_BITS-1:0]  r_blk;
    logic                   r_io_ok;

    // Output registers
    logic                   r_strobe;
    dmwbc_pkg::t_resp_kind  r_kind, n_kind;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [BLOCK_BITS-1:0]  r_tgt, n_tgt;
    logic                   r_hit, n_hit;

    // Entry store ports
    logic                   w_accept;
    logic                   w_we;
    logic [SLOT_W-1:0]      w_waddr;
    logic [ENT_W-1:0]       w_wdata;
    logic [ENT_W-1:0]       w_rdata;
    logic                   e_we;
    logic [SLOT_W-1:0]      e_waddr;
    logic [ENT_W-1:0]       e_wdata;

    // Entry fields and request split
    logic                   w_ent_valid;
    logic                   w_ent_dirty;
    logic [TAG_W-1:0]       w_ent_tag;
    logic [SLOT_W-1:0]      w_req_slot;
    logic [TAG_W-1:0]       w_req_tag;
    logic [SLOT_W-1:0]      w_pend_slot;

    // Allocation request from the decision logic
    logic                   a_go;
    logic [BLOCK_BITS-1:0]  a_blk;
    logic                   a_wr;

    assign busy     = r_clear | r_exec;
    assign w_accept = start & ~busy;

    assign w_ent_valid = w_rdata[ENT_W-1];
    assign w_ent_dirty = w_rdata[ENT_W-2];
    assign w_ent_tag   = w_rdata[TAG_W-1:0];
    assign w_req_slot  = r_blk[SLOT_W-1:0];
    assign w_req_tag   = r_blk[BLOCK_BITS-1:SLOT_W];
    assign w_pend_slot = r_pend_blk[SLOT_W-1:0];

    dmwbc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (i_block_number[SLOT_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Route the clearing pass or the item's entry update to the write port
    always_comb begin
        if (r_clear) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '0;
        end else begin
            w_we    = e_we;
            w_waddr = e_waddr;
            w_wdata = e_wdata;
        end
    end

    // Decide the response and the entry update for the item under work
    always_comb begin
        n_phase    = r_phase;
        n_pend_blk = r_pend_blk;
        n_pend_wr  = r_pend_wr;
        n_kind     = dmwbc_pkg::RESP_ORDER;
        n_slot     = '0;
        n_tgt      = '0;
        n_hit      = 1'b0;
        e_we       = 1'b0;
        e_waddr    = w_req_slot;
        e_wdata    = {2'b11, w_req_tag};
        a_go       = 1'b0;
        a_blk      = r_blk;
        a_wr       = 1'b0;

        unique case (r_phase)
            dmwbc_pkg::PH_IDLE: begin
                if (r_req_type == dmwbc_pkg::REQ_READ ||
                    r_req_type == dmwbc_pkg::REQ_WRITE) begin
                    if (w_ent_valid && w_ent_tag == w_req_tag) begin
                        // hit: complete, mark dirty on a write
                        n_kind = dmwbc_pkg::RESP_DONE;
                        n_slot = w_req_slot;
                        n_tgt  = r_blk;
                        n_hit  = 1'b1;
                        e_we   = (r_req_type == dmwbc_pkg::REQ_WRITE);
                    end else if (w_ent_valid && w_ent_dirty) begin
                        // dirty victim: command its writeback and wait
                        n_kind     = dmwbc_pkg::RESP_WBACK;
                        n_slot     = w_req_slot;
                        n_tgt      = {w_ent_tag, w_req_slot};
                        n_pend_blk = r_blk;
                        n_pend_wr  = (r_req_type == dmwbc_pkg::REQ_WRITE);
                        n_phase    = dmwbc_pkg::PH_WBACK;
                    end else begin
                        a_go  = 1'b1;
                        a_blk = r_blk;
                        a_wr  = (r_req_type == dmwbc_pkg::REQ_WRITE);
                    end
                end
            end
            dmwbc_pkg::PH_WBACK: begin
                if (r_req_type == dmwbc_pkg::REQ_WB_DONE) begin
                    if (!r_io_ok) begin
                        // failed writeback: keep the entry, report the error
                        n_kind  = dmwbc_pkg::RESP_IOERR;
                        n_slot  = w_pend_slot;
                        n_tgt   = r_pend_blk;
                        n_phase = dmwbc_pkg::PH_IDLE;
                    end else begin
                        a_go  = 1'b1;
                        a_blk = r_pend_blk;
                        a_wr  = r_pend_wr;
                    end
                end
            end
            dmwbc_pkg::PH_FILL: begin
                if (r_req_type == dmwbc_pkg::REQ_FILL_DONE) begin
                    n_phase = dmwbc_pkg::PH_IDLE;
                    n_slot  = w_pend_slot;
                    n_tgt   = r_pend_blk;
                    if (!r_io_ok) begin
                        // failed fill: drop the slot
                        n_kind  = dmwbc_pkg::RESP_IOERR;
                        e_we    = 1'b1;
                        e_waddr = w_pend_slot;
                        e_wdata = {2'b00, r_pend_blk[BLOCK_BITS-1:SLOT_W]};
                    end else begin
                        n_kind = dmwbc_pkg::RESP_DONE;
                    end
                end
            end
            default: begin
                n_phase = dmwbc_pkg::PH_IDLE;
            end
        endcase

        // Allocate the slot for a miss with no victim left
        if (a_go) begin
            e_we    = 1'b1;
            e_waddr = a_blk[SLOT_W-1:0];
            e_wdata = {1'b1, a_wr, a_blk[BLOCK_BITS-1:SLOT_W]};
            n_slot  = a_blk[SLOT_W-1:0];
            n_tgt   = a_blk;
            if (a_wr) begin
                n_kind  = dmwbc_pkg::RESP_DONE;
                n_phase = dmwbc_pkg::PH_IDLE;
            end else begin
                n_kind     = dmwbc_pkg::RESP_FILL;
                n_pend_blk = a_blk;
                n_pend_wr  = 1'b0;
                n_phase    = dmwbc_pkg::PH_FILL;
            end
        end

        if (!r_exec) begin
            e_we = 1'b0;
        end
    end

    // Clearing pass, item sequencing and wait state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear    <= 1'b1;
            r_clr_idx  <= '0;
            r_exec     <= 1'b0;
            r_phase    <= dmwbc_pkg::PH_IDLE;
            r_pend_blk <= '0;
            r_pend_wr  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (r_clear) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == SLOT_W'(SLOTS - 1)) begin
                    r_clear <= 1'b0;
                end
            end
            r_exec   <= w_accept;
            r_strobe <= r_exec;
            if (r_exec) begin
                r_phase    <= n_phase;
                r_pend_blk <= n_pend_blk;
                r_pend_wr  <= n_pend_wr;
            end
        end
    end

    // Capture the item at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= dmwbc_pkg::t_req_type'(i_req_type);
            r_blk      <= i_block_number;
            r_io_ok    <= i_io_ok;
        end
    end

    // Hold the response for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (r_exec) begin
            r_kind <= n_kind;
            r_slot <= n_slot;
            r_tgt  <= n_tgt;
            r_hit  <= n_hit;
        end
    end

    assign o_resp_strobe  = r_strobe;
    assign o_resp_kind    = r_kind;
    assign o_slot         = r_slot;
    assign o_target_block = r_tgt;
    assign o_was_hit      = r_hit;

endmodule

// File: src/dmwbc_checker.sv
// Port-level checker for the cache controller and its bind.
`timescale 1ns / 1ps

module dmwbc_checker #(
    parameter int SLOTS      = 64,
    parameter int BLOCK_BITS = 48
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [1:0]               i_req_type,
    input logic [BLOCK_BITS-1:0]    i_block_number,
    input logic                     i_io_ok,
    input logic                     o_resp_strobe,
    input logic [2:0]               o_resp_kind,
    input logic [$clog2(SLOTS)-1:0] o_slot,
    input logic [BLOCK_BITS-1:0]    o_target_block,
    input logic                     o_was_hit
);

    // Every accepted item is answered by a response strobe
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_resp_strobe)
        else $error("no response two cycles after accept");

    // No response without an earlier accepted item
    a_resp_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_strobe |-> $past(start && !busy, 2))
        else $error("response without accepted item");

    // Strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_strobe |=> !o_resp_strobe)
        else $error("strobe held longer than one cycle");

    // Out-of-order answers carry zero fields
    a_order_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_strobe && o_resp_kind == dmwbc_pkg::RESP_ORDER) |->
            (o_slot == '0 && o_target_block == '0 && !o_was_hit))
        else $error("out-of-order response with nonzero fields");

    // A hit always completes
    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_strobe && o_was_hit) |-> (o_resp_kind == dmwbc_pkg::RESP_DONE))
        else $error("hit with a response other than complete");

endmodule

bind direct_mapped_writeback_cache dmwbc_checker #(
    .SLOTS      (SLOTS),
    .BLOCK_BITS (BLOCK_BITS)
) u_dmwbc_checker (.*);

// File: test/direct_mapped_writeback_cache_tb.sv
// Self-checking testbench of the direct-mapped write-back cache controller.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_tb;

    localparam int SLOTS       = 64;
    localparam int BLOCK_BITS  = 48;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int TAG_W       = BLOCK_BITS - SLOT_W;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        dmwbc_pkg::t_resp_kind kind;
        logic [SLOT_W-1:0]     slot;
        logic [BLOCK_BITS-1:0] target;
        logic                  hit;
    } t_outcome;

    typedef struct {
        dmwbc_pkg::t_req_type  ty;
        logic [BLOCK_BITS-1:0] blk;
        logic                  ok;
        bit                    typed;
        t_outcome              want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    dmwbc_pkg::t_req_type  req_type = dmwbc_pkg::REQ_READ;
    logic [BLOCK_BITS-1:0] block_number = '0;
    logic                  io_ok = 1'b0;
    logic                  o_resp_strobe;
    logic [2:0]            o_resp_kind;
    logic [SLOT_W-1:0]     o_slot;
    logic [BLOCK_BITS-1:0] o_target_block;
    logic                  o_was_hit;

    // Cache state as the predictor sees it
    logic [TAG_W-1:0]      tag_mem [SLOTS];
    bit                    valid_mem [SLOTS];
    bit                    dirty_mem [SLOTS];
    dmwbc_pkg::t_phase     phase = dmwbc_pkg::PH_IDLE;
    bit                    pend_write = 1'b0;
    logic [BLOCK_BITS-1:0] pend_blk = '0;

    t_outcome              pending_results [$];
    t_row                  directed_rows [$];
    logic [TAG_W-1:0]      tag_pool [4];
    int                    err_count = 0;
    int                    cycle_count = 0;

    direct_mapped_writeback_cache #(
        .SLOTS      (SLOTS),
        .BLOCK_BITS (BLOCK_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (req_type),
        .i_block_number (block_number),
        .i_io_ok        (io_ok),
        .o_resp_strobe  (o_resp_strobe),
        .o_resp_kind    (o_resp_kind),
        .o_slot         (o_slot),
        .o_target_block (o_target_block),
        .o_was_hit      (o_was_hit)
    );

    always #2 i_clk = ~i_clk;

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("direct_mapped_writeback_cache_tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [BLOCK_BITS-1:0] want,
                                   logic [BLOCK_BITS-1:0] got);
        err_count++;
        $display("%0t: %s mismatch, want %h got %h", $time, what, want, got);
    endtask

    // Install a block in its slot once no dirty victim is in the way
    function automatic t_outcome allocate_slot(logic [BLOCK_BITS-1:0] blk, bit is_write);
        logic [SLOT_W-1:0] s;
        t_outcome          r;
        s = blk[SLOT_W-1:0];
        tag_mem[s] = blk[BLOCK_BITS-1:SLOT_W];
        valid_mem[s] = 1'b1;
        dirty_mem[s] = is_write;
        r.slot = s;
        r.target = blk;
        r.hit = 1'b0;
        if (is_write) begin
            phase = dmwbc_pkg::PH_IDLE;
            r.kind = dmwbc_pkg::RESP_DONE;
        end else begin
            pend_blk = blk;
            pend_write = 1'b0;
            phase = dmwbc_pkg::PH_FILL;
            r.kind = dmwbc_pkg::RESP_FILL;
        end
        return r;
    endfunction

    // Advance the cache state by one item and return its response
    function automatic t_outcome cache_predict(dmwbc_pkg::t_req_type ty,
                                               logic [BLOCK_BITS-1:0] blk, logic ok);
        logic [SLOT_W-1:0] s;
        t_outcome          r;
        r.kind = dmwbc_pkg::RESP_ORDER;
        r.slot = '0;
        r.target = '0;
        r.hit = 1'b0;
        case (phase)
            dmwbc_pkg::PH_IDLE: begin
                if (ty == dmwbc_pkg::REQ_READ || ty == dmwbc_pkg::REQ_WRITE) begin
                    s = blk[SLOT_W-1:0];
                    if (valid_mem[s] && tag_mem[s] == blk[BLOCK_BITS-1:SLOT_W]) begin
                        if (ty == dmwbc_pkg::REQ_WRITE)
                            dirty_mem[s] = 1'b1;
                        r.kind = dmwbc_pkg::RESP_DONE;
                        r.slot = s;
                        r.target = blk;
                        r.hit = 1'b1;
                    end else if (valid_mem[s] && dirty_mem[s]) begin
                        pend_blk = blk;
                        pend_write = (ty == dmwbc_pkg::REQ_WRITE);
                        phase = dmwbc_pkg::PH_WBACK;
                        r.kind = dmwbc_pkg::RESP_WBACK;
                        r.slot = s;
                        r.target = {tag_mem[s], s};
                    end else begin
                        r = allocate_slot(blk, ty == dmwbc_pkg::REQ_WRITE);
                    end
                end
            end
            dmwbc_pkg::PH_WBACK: begin
                if (ty == dmwbc_pkg::REQ_WB_DONE) begin
                    s = pend_blk[SLOT_W-1:0];
                    if (!ok) begin
                        phase = dmwbc_pkg::PH_IDLE;
                        r.kind = dmwbc_pkg::RESP_IOERR;
                        r.slot = s;
                        r.target = pend_blk;
                    end else begin
                        dirty_mem[s] = 1'b0;
                        r = allocate_slot(pend_blk, pend_write);
                    end
                end
            end
            default: begin
                if (ty == dmwbc_pkg::REQ_FILL_DONE) begin
                    s = pend_blk[SLOT_W-1:0];
                    phase = dmwbc_pkg::PH_IDLE;
                    if (!ok)
                        valid_mem[s] = 1'b0;
                    r.kind = ok ? dmwbc_pkg::RESP_DONE : dmwbc_pkg::RESP_IOERR;
                    r.slot = s;
                    r.target = pend_blk;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(dmwbc_pkg::t_req_type ty, logic [BLOCK_BITS-1:0] blk,
                                    logic ok, bit typed = 1'b0,
                                    dmwbc_pkg::t_resp_kind kind = dmwbc_pkg::RESP_DONE,
                                    logic [SLOT_W-1:0] s = '0,
                                    logic [BLOCK_BITS-1:0] tgt = '0, logic hit = 1'b0);
        t_row row;
        row.ty = ty;
        row.blk = blk;
        row.ok = ok;
        row.typed = typed;
        row.want.kind = kind;
        row.want.slot = s;
        row.want.target = tgt;
        row.want.hit = hit;
        directed_rows.push_back(row);
    endfunction

    // Present one item, hold it until taken, then record its expected response and at random idle a bit
    task automatic issue(t_row item, int idle_pct);
        t_outcome pred;
        req_type <= item.ty;
        block_number <= item.blk;
        io_ok <= item.ok;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = cache_predict(item.ty, item.blk, item.ok);
        pending_results.push_back(item.typed ? item.want : pred);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Hold off new items until every response is in
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Mostly well-formed request and report sequences, with stray items mixed in
    task automatic run_random(int count, int idle_pct);
        t_row              item;
        int                pick;
        logic [63:0]       wide;
        logic [SLOT_W-1:0] s;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            item.typed = 1'b0;
            item.want = '0;
            item.ok = ($urandom_range(9) != 0);
            s = $urandom_range(1) ? SLOT_W'($urandom_range(7)) : SLOT_W'($urandom_range(63));
            wide = {$urandom, $urandom};
            item.blk = ($urandom_range(9) < 8) ? {tag_pool[$urandom_range(3)], s}
                                                : wide[BLOCK_BITS-1:0];
            case (phase)
                dmwbc_pkg::PH_WBACK:
                    item.ty = (pick < 85) ? dmwbc_pkg::REQ_WB_DONE
                                          : dmwbc_pkg::t_req_type'($urandom_range(3));
                dmwbc_pkg::PH_FILL:
                    item.ty = (pick < 85) ? dmwbc_pkg::REQ_FILL_DONE
                                          : dmwbc_pkg::t_req_type'($urandom_range(3));
                default:
                    item.ty = (pick < 90) ? dmwbc_pkg::t_req_type'($urandom_range(1))
                                          : dmwbc_pkg::t_req_type'($urandom_range(3));
            endcase
            issue(item, idle_pct);
        end
    endtask

    // Compare each response with the oldest outstanding one
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_resp_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unsolicited resp_kind", '0, BLOCK_BITS'(o_resp_kind));
            end else begin
                want = pending_results.pop_front();
                if (o_resp_kind !== want.kind)
                    report_mismatch("resp_kind", BLOCK_BITS'(want.kind), BLOCK_BITS'(o_resp_kind));
                if (o_slot !== want.slot)
                    report_mismatch("slot", BLOCK_BITS'(want.slot), BLOCK_BITS'(o_slot));
                if (o_target_block !== want.target)
                    report_mismatch("target_block", want.target, o_target_block);
                if (o_was_hit !== want.hit)
                    report_mismatch("was_hit", BLOCK_BITS'(want.hit), BLOCK_BITS'(o_was_hit));
            end
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_W'({$urandom, $urandom});
        tag_pool[3] = TAG_W'({$urandom, $urandom});

        // Stray reports, misses, hits, failed and good writebacks and fills, wide blocks
        add_row(dmwbc_pkg::REQ_FILL_DONE, '1, 1'b1, 1'b1, dmwbc_pkg::RESP_ORDER);
        add_row(dmwbc_pkg::REQ_WB_DONE, '0, 1'b0, 1'b1, dmwbc_pkg::RESP_ORDER);
        add_row(dmwbc_pkg::REQ_READ, 48'd0, 1'b0, 1'b1,
                dmwbc_pkg::RESP_FILL, 6'd0, 48'd0, 1'b0);
        add_row(dmwbc_pkg::REQ_WRITE, 48'd5, 1'b1, 1'b1, dmwbc_pkg::RESP_ORDER);
        add_row(dmwbc_pkg::REQ_WB_DONE, 48'd0, 1'b1, 1'b1, dmwbc_pkg::RESP_ORDER);
        add_row(dmwbc_pkg::REQ_FILL_DONE, 48'd0, 1'b1, 1'b1,
                dmwbc_pkg::RESP_DONE, 6'd0, 48'd0, 1'b0);
        add_row(dmwbc_pkg::REQ_READ, 48'd0, 1'b0, 1'b1,
                dmwbc_pkg::RESP_DONE, 6'd0, 48'd0, 1'b1);
        add_row(dmwbc_pkg::REQ_WRITE, 48'd0, 1'b0, 1'b1,
                dmwbc_pkg::RESP_DONE, 6'd0, 48'd0, 1'b1);
        add_row(dmwbc_pkg::REQ_READ, 48'd64, 1'b0, 1'b1,
                dmwbc_pkg::RESP_WBACK, 6'd0, 48'd0, 1'b0);
        add_row(dmwbc_pkg::REQ_FILL_DONE, 48'd0, 1'b1, 1'b1, dmwbc_pkg::RESP_ORDER);
        add_row(dmwbc_pkg::REQ_WB_DONE, 48'd0, 1'b0, 1'b1,
                dmwbc_pkg::RESP_IOERR, 6'd0, 48'd64, 1'b0);
        add_row(dmwbc_pkg::REQ_READ, 48'd0, 1'b0, 1'b1,
                dmwbc_pkg::RESP_DONE, 6'd0, 48'd0, 1'b1);
        add_row(dmwbc_pkg::REQ_READ, 48'd64, 1'b0, 1'b1,
                dmwbc_pkg::RESP_WBACK, 6'd0, 48'd0, 1'b0);
        add_row(dmwbc_pkg::REQ_WB_DONE, 48'd0, 1'b1, 1'b1,
                dmwbc_pkg::RESP_FILL, 6'd0, 48'd64, 1'b0);
        add_row(dmwbc_pkg::REQ_FILL_DONE, 48'd0, 1'b0, 1'b1,
                dmwbc_pkg::RESP_IOERR, 6'd0, 48'd64, 1'b0);
        add_row(dmwbc_pkg::REQ_READ, 48'd0, 1'b0, 1'b1,
                dmwbc_pkg::RESP_FILL, 6'd0, 48'd0, 1'b0);
        add_row(dmwbc_pkg::REQ_FILL_DONE, '1, 1'b1, 1'b1,
                dmwbc_pkg::RESP_DONE, 6'd0, 48'd0, 1'b0);
        add_row(dmwbc_pkg::REQ_WRITE, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_row(dmwbc_pkg::REQ_WRITE, 48'hFFFF_FFFF_FFFF, 1'b0);
        add_row(dmwbc_pkg::REQ_READ, 48'h0000_0000_003F, 1'b1);
        add_row(dmwbc_pkg::REQ_WB_DONE, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_row(dmwbc_pkg::REQ_FILL_DONE, 48'd0, 1'b1);
        add_row(dmwbc_pkg::REQ_WRITE, 48'hAAAA_AAAA_AAAA, 1'b0);
        add_row(dmwbc_pkg::REQ_WRITE, 48'h5555_5555_5555, 1'b1);
        add_row(dmwbc_pkg::REQ_READ, 48'hAAAA_AAAA_AAAA, 1'b0);

        foreach (directed_rows[i])
            issue(directed_rows[i], 7);
        wait_drained();

        // Light sender gaps, then heavy ones, then back to back
        run_random(375, 7);
        wait_drained();
        run_random(375, 46);
        wait_drained();
        run_random(375, 0);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("direct_mapped_writeback_cache_tb: done, clean");
        end else begin
            $display("direct_mapped_writeback_cache_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
src/dmwbc_pkg.sv
src/dmwbc_ram.sv
src/direct_mapped_writeback_cache.sv
src/dmwbc_checker.sv
test/direct_mapped_writeback_cache_tb.sv
